/* design/shader_sampler_mask_scan_assert.svh */
// Assertion macros for the shader sampler mask scan block.
`ifndef SHADER_SAMPLER_MASK_SCAN_ASSERT_SVH
`define SHADER_SAMPLER_MASK_SCAN_ASSERT_SVH

// Clocked assertion, off while reset is high.
`define SSMS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ssms assertion failed");

// Clocked assertion that also holds across reset.
`define SSMS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ssms assertion failed");

`endif

/* design/ssms_pkg.sv */
// Types, constants and codes shared by the shader sampler mask scan files.
package ssms_pkg;

   localparam int SAMPLER_SLOTS = 21;
   localparam int MaskWidth     = 21;

   typedef logic [MaskWidth-1:0] mask_type;

   localparam mask_type AllSlots = mask_type'((64'd1 << SAMPLER_SLOTS) - 64'd1);

   localparam logic [15:0] KindPixel      = 16'hffff;
   localparam logic [15:0] KindVertex     = 16'hfffe;
   localparam logic [15:0] OpEnd          = 16'hffff;
   localparam logic [15:0] OpComment      = 16'hfffe;
   localparam logic [15:0] OpDcl          = 16'd31;
   localparam logic [4:0]  RegTypeSampler = 5'd10;
   localparam logic [4:0]  VertexBase     = 5'd17;

   typedef enum logic [2:0] {
      PHASE_VERSION = 3'b001,
      PHASE_SCAN    = 3'b010,
      PHASE_DONE    = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      POS_NONE  = 3'b001,
      POS_USAGE = 3'b010,
      POS_REG   = 3'b100
   } pos_type;

   typedef struct packed {
      phase_type   phase;
      logic        is_pixel;
      logic [15:0] skip;
      pos_type     pos;
      mask_type    found;
   } state_type;

   typedef struct packed {
      logic [31:0] token;
      logic        last;
      logic        empty_program;
   } item_type;

   localparam state_type StateReset = '{
      phase:    PHASE_VERSION,
      is_pixel: 1'b0,
      skip:     16'd0,
      pos:      POS_NONE,
      found:    '0
   };

endpackage

/* design/ssms_if.sv */
// Request and response channel interfaces of the shader sampler mask scan block.
interface ssms_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] token;
   logic        last;
   logic        empty_program;

   modport source (output valid, output token, output last, output empty_program,
                   input ready);
   modport sink   (input valid, input token, input last, input empty_program,
                   output ready);
endinterface

interface ssms_rsp_if import ssms_pkg::*; ();
   logic     valid;
   logic     ready;
   mask_type sampler_mask;

   modport source (output valid, output sampler_mask, input ready);
   modport sink   (input valid, input sampler_mask, output ready);
endinterface

/* design/ssms_step.sv */
// Next-state and result logic for one token of the sampler scan.
module ssms_step import ssms_pkg::*; (
   input  state_type cur,
   input  item_type  item,
   output state_type upd,
   output logic      emit,
   output mask_type  mask
);

   logic [15:0] kind;
   logic [7:0]  major;
   logic [7:0]  minor;
   logic        is_pix;
   logic        is_vtx;
   logic [15:0] op;
   logic [3:0]  len;
   logic [4:0]  rtype;
   logic [10:0] regnum;
   mask_type    hit;

   assign kind   = item.token[31:16];
   assign major  = item.token[15:8];
   assign minor  = item.token[7:0];
   assign is_pix = (kind == KindPixel);
   assign is_vtx = (kind == KindVertex);
   assign op     = item.token[15:0];
   assign len    = item.token[27:24];
   assign rtype  = {item.token[12:11], item.token[30:28]};
   assign regnum = item.token[10:0];

   always_comb begin
      hit = '0;
      if (rtype == RegTypeSampler) begin
         if (cur.is_pixel) begin
            if (regnum < 11'd16) begin
               hit = mask_type'(1) << regnum[3:0];
            end
         end else if (regnum < 11'd4) begin
            hit = mask_type'(1) << (VertexBase + {3'b000, regnum[1:0]});
         end
      end
   end

   always_comb begin
      upd  = cur;
      emit = item.last | item.empty_program;
      mask = '0;
      if (item.empty_program) begin
         upd  = StateReset;
         mask = AllSlots;
      end else begin
         case (cur.phase)
            PHASE_VERSION: begin
               upd.is_pixel = is_pix;
               upd.skip     = '0;
               upd.pos      = POS_NONE;
               if (!is_pix && !is_vtx) begin
                  upd.found = AllSlots;
                  upd.phase = PHASE_DONE;
               end else if (major < 8'd2) begin
                  if (is_pix) begin
                     upd.found = (minor >= 8'd4) ? mask_type'(6'h3f) : mask_type'(4'hf);
                  end else begin
                     upd.found = '0;
                  end
                  upd.phase = PHASE_DONE;
               end else if (is_vtx && major < 8'd3) begin
                  upd.found = '0;
                  upd.phase = PHASE_DONE;
               end else begin
                  upd.found = '0;
                  upd.phase = PHASE_SCAN;
               end
            end
            PHASE_SCAN: begin
               if (cur.skip != 16'd0) begin
                  upd.skip = cur.skip - 16'd1;
                  case (cur.pos)
                     POS_USAGE: begin
                        upd.pos = POS_REG;
                     end
                     POS_REG: begin
                        upd.found = cur.found | hit;
                        upd.pos   = POS_NONE;
                     end
                     default: begin
                        upd.pos = cur.pos;
                     end
                  endcase
               end else begin
                  upd.pos = POS_NONE;
                  if (op == OpEnd) begin
                     upd.phase = PHASE_DONE;
                  end else if (op == OpComment) begin
                     upd.skip = {1'b0, item.token[30:16]};
                  end else begin
                     upd.skip = {12'd0, len};
                     if (op == OpDcl && len >= 4'd2) begin
                        upd.pos = POS_USAGE;
                     end
                  end
               end
            end
            default: begin
               upd = cur;
            end
         endcase
         mask = upd.found;
         if (item.last) begin
            upd = StateReset;
         end
      end
   end

endmodule

/* design/shader_sampler_mask_scan.sv */
// Top level: sampler slot scan over a shader token stream.
// An accepted request is held in the input register, and its response in the response register.
// Throughput: one token per cycle; a stalled response backs up into the input register.
// Only the last token of a program, or an empty-program request, yields a response.
// Reset (synchronous, active high) drops any held request and response
// and returns the scan to waiting for a version token.
module shader_sampler_mask_scan import ssms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ssms_req_if.sink    req_bus,
   ssms_rsp_if.source  rsp_bus
);

   logic      s1_valid_ff, s1_valid_in;
   item_type  s1_item_ff, s1_item_in;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   mask_type  rsp_mask_ff, rsp_mask_in;

   state_type step_upd;
   logic      step_emit;
   mask_type  step_mask;
   logic      req_accept;
   logic      out_free;
   logic      advance;
   item_type  req_item;

   ssms_step u_step (
      .cur  (state_ff),
      .item (s1_item_ff),
      .upd  (step_upd),
      .emit (step_emit),
      .mask (step_mask)
   );

   assign req_item = '{token: req_bus.token, last: req_bus.last,
                       empty_program: req_bus.empty_program};

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign advance       = s1_valid_ff && (!step_emit || out_free);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign s1_item_in   = req_accept ? req_item : s1_item_ff;
   assign state_in     = advance ? step_upd : state_ff;
   assign rsp_valid_in = (advance && step_emit) ? 1'b1 :
                         (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_mask_in  = (advance && step_emit) ? step_mask : rsp_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         state_ff     <= StateReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.sampler_mask = rsp_mask_ff;

endmodule

/* design/ssms_checker.sv */
// Port-level checker for the shader sampler mask scan block, with its bind.
`include "shader_sampler_mask_scan_assert.svh"

module ssms_checker import ssms_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     req_last,
   input logic     req_empty_program,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input mask_type rsp_sampler_mask
);

   `SSMS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sampler_mask))
   `SSMS_ASSERT(a_rsp_source, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_last || req_empty_program), 2))
   `SSMS_ASSERT(a_ready_when_idle, clock, reset, !rsp_valid |-> req_ready)
   `SSMS_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid)

endmodule

bind shader_sampler_mask_scan ssms_checker u_ssms_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .req_last          (req_bus.last),
   .req_empty_program (req_bus.empty_program),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_sampler_mask  (rsp_bus.sampler_mask)
);

/* test/tb_shader_sampler_mask_scan.sv */
// Testbench for the shader sampler mask scan: token streams driven, predicted masks checked.
module tb_shader_sampler_mask_scan import ssms_pkg::*; ();

   localparam int          IdleLimit        = 2000;
   localparam int          DrainCycles      = 8;
   localparam int          PhaseItems       = 450;
   localparam mask_type    LegacyWideMask   = 21'h3f;
   localparam mask_type    LegacyNarrowMask = 21'hf;
   localparam logic [15:0] OpMov            = 16'h0001;

   class mask_tracker;
      phase_type   phase;
      logic        pixel;
      logic [15:0] skip;
      pos_type     pos;
      mask_type    found;
      mask_type    pending_masks[$];
      int          errors;

      function new();
         errors = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         phase = PHASE_VERSION;
         pixel = 1'b0;
         skip  = '0;
         pos   = POS_NONE;
         found = '0;
      endfunction

      function void take_version(logic [31:0] v);
         logic [15:0] kind;
         logic [7:0]  major;
         logic [7:0]  minor;
         logic        pix;
         logic        vtx;
         kind  = v[31:16];
         major = v[15:8];
         minor = v[7:0];
         pix   = (kind == KindPixel);
         vtx   = (kind == KindVertex);
         pixel = pix;
         skip  = '0;
         pos   = POS_NONE;
         if (!pix && !vtx) begin
            found = AllSlots;
            phase = PHASE_DONE;
         end else if (major < 8'd2) begin
            found = pix ? ((minor >= 8'd4) ? LegacyWideMask : LegacyNarrowMask) : '0;
            phase = PHASE_DONE;
         end else if (vtx && major < 8'd3) begin
            found = '0;
            phase = PHASE_DONE;
         end else begin
            found = '0;
            phase = PHASE_SCAN;
         end
      endfunction

      function void take_register(logic [31:0] dst);
         logic [4:0]  rtype;
         logic [10:0] regn;
         rtype = {dst[12:11], dst[30:28]};
         regn  = dst[10:0];
         if (rtype != RegTypeSampler) return;
         if (pixel) begin
            if (regn < 11'd16) found[regn[3:0]] = 1'b1;
         end else if (regn < 11'd4) begin
            found[int'(VertexBase) + int'(regn[1:0])] = 1'b1;
         end
      endfunction

      function void take_body(logic [31:0] tok);
         logic [15:0] op;
         logic [3:0]  len;
         op = tok[15:0];
         if (skip != 16'd0) begin
            skip = skip - 16'd1;
            if (pos == POS_USAGE) begin
               pos = POS_REG;
            end else if (pos == POS_REG) begin
               take_register(tok);
               pos = POS_NONE;
            end
            return;
         end
         pos = POS_NONE;
         if (op == OpEnd) begin
            phase = PHASE_DONE;
            return;
         end
         if (op == OpComment) begin
            skip = {1'b0, tok[30:16]};
            return;
         end
         len  = tok[27:24];
         skip = {12'd0, len};
         if (op == OpDcl && len >= 4'd2) pos = POS_USAGE;
      endfunction

      function void note_token(item_type it);
         if (it.empty_program) begin
            clear_scan();
            pending_masks.push_back(AllSlots);
            return;
         end
         if (phase == PHASE_VERSION) take_version(it.token);
         else if (phase == PHASE_SCAN) take_body(it.token);
         if (it.last) begin
            pending_masks.push_back(found);
            clear_scan();
         end
      endfunction

      function void check_mask(mask_type actual);
         mask_type want;
         if (pending_masks.size() == 0) begin
            $error("sampler_mask: no response expected, actual %h", actual);
            errors++;
            return;
         end
         want = pending_masks.pop_front();
         if (want !== actual) begin
            $error("sampler_mask: expected %h, actual %h", want, actual);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   mask_tracker tracker = new();
   item_type    stream_q[$];
   int          send_idle = 0;
   int          recv_stall = 0;
   int          idle_cycles = 0;

   ssms_req_if req_if();
   ssms_rsp_if rsp_if();

   shader_sampler_mask_scan u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) tracker.check_mask(rsp_if.sampler_mask);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IdleLimit) @(posedge clock);
      $display("shader_sampler_mask_scan: mismatch");
      $finish;
   end

   function automatic logic [31:0] op_token(logic [15:0] op, int len);
      logic [31:0] t;
      t        = $urandom();
      t[27:24] = len[3:0];
      t[15:0]  = op;
      return t;
   endfunction

   function automatic logic [31:0] comment_token(int len);
      logic [31:0] t;
      t        = $urandom();
      t[30:16] = len[14:0];
      t[15:0]  = OpComment;
      return t;
   endfunction

   function automatic logic [31:0] sampler_token(logic [10:0] regn);
      logic [31:0] t;
      t        = $urandom();
      t[30:28] = RegTypeSampler[2:0];
      t[12:11] = RegTypeSampler[4:3];
      t[10:0]  = regn;
      return t;
   endfunction

   function void push_token(logic [31:0] tok, logic is_last);
      item_type it;
      it.token         = tok;
      it.last          = is_last;
      it.empty_program = 1'b0;
      stream_q.push_back(it);
   endfunction

   function void push_empty();
      item_type it;
      it.token         = $urandom();
      it.last          = 1'($urandom_range(0, 1));
      it.empty_program = 1'b1;
      stream_q.push_back(it);
   endfunction

   function void push_words(int count);
      repeat (count) push_token($urandom(), 1'b0);
   endfunction

   function void queue_directed();
      push_empty();
      push_token(32'h0000_0000, 1'b1);
      push_token({KindPixel, 8'd1, 8'd4}, 1'b1);
      push_token({KindPixel, 8'd1, 8'd3}, 1'b1);
      push_token({KindVertex, 8'd1, 8'd1}, 1'b1);
      push_token({KindVertex, 8'd2, 8'd0}, 1'b1);
      push_token({KindVertex, 8'd3, 8'd0}, 1'b1);
      // pixel program: comment, sampler s15, plain op, end, trailing token
      push_token({KindPixel, 8'd3, 8'd0}, 1'b0);
      push_token(comment_token(1), 1'b0);
      push_token(32'hffff_ffff, 1'b0);
      push_token(op_token(OpDcl, 2), 1'b0);
      push_token(32'h0000_0000, 1'b0);
      push_token(sampler_token(11'd15), 1'b0);
      push_token(op_token(OpMov, 1), 1'b0);
      push_token(32'h0000_0000, 1'b0);
      push_token(op_token(OpEnd, 0), 1'b0);
      push_token(32'hffff_ffff, 1'b1);
      // vertex program: sampler s3, then a declaration cut short by last
      push_token({KindVertex, 8'd3, 8'd0}, 1'b0);
      push_token(op_token(OpDcl, 3), 1'b0);
      push_token(32'h8000_0000, 1'b0);
      push_token(sampler_token(11'd3), 1'b0);
      push_token(32'h0000_0000, 1'b0);
      push_token(op_token(OpDcl, 2), 1'b0);
      push_token(32'h8000_0000, 1'b1);
      // abandon a program in progress
      push_token({KindPixel, 8'd2, 8'd0}, 1'b0);
      push_empty();
   endfunction

   function void queue_program();
      logic [15:0] kind;
      logic [7:0]  major;
      logic [15:0] op;
      logic [10:0] regn;
      int          pick;
      int          len;
      int          cut;
      pick = $urandom_range(0, 99);
      if (pick < 45) kind = KindPixel;
      else if (pick < 85) kind = KindVertex;
      else kind = 16'($urandom_range(0, 16'hfffd));
      pick = $urandom_range(0, 99);
      if (pick < 70) major = 8'($urandom_range(2, 3));
      else if (pick < 90) major = 8'($urandom_range(0, 1));
      else major = 8'($urandom());
      push_token({kind, major, 8'($urandom())}, 1'b0);
      repeat ($urandom_range(0, 8)) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            len = $urandom_range(2, 4);
            push_token(op_token(OpDcl, len), 1'b0);
            push_words(1);
            if ($urandom_range(0, 3) == 0) regn = 11'($urandom());
            else regn = 11'($urandom_range(0, 19));
            push_token(sampler_token(regn), 1'b0);
            push_words(len - 2);
         end else if (pick < 55) begin
            len = $urandom_range(0, 4);
            push_token(op_token(OpDcl, len), 1'b0);
            push_words(len);
         end else if (pick < 75) begin
            len = $urandom_range(0, 4);
            push_token(comment_token(len), 1'b0);
            push_words(len);
         end else if (pick < 95) begin
            op = 16'($urandom_range(0, 16'hfffd));
            if (op == OpDcl) op = OpMov;
            len = $urandom_range(0, 15);
            push_token(op_token(op, len), 1'b0);
            push_words(len);
         end else begin
            push_token(op_token(OpEnd, $urandom_range(0, 15)), 1'b0);
         end
      end
      if ($urandom_range(0, 99) < 80) push_token(op_token(OpEnd, $urandom_range(0, 15)), 1'b0);
      push_words($urandom_range(0, 2));
      if ($urandom_range(0, 99) < 10 && stream_q.size() > 1) begin
         cut = $urandom_range(1, stream_q.size() - 1);
         while (stream_q.size() > cut) void'(stream_q.pop_back());
      end
      if ($urandom_range(0, 99) < 5) push_empty();
      else stream_q[$].last = 1'b1;
   endfunction

   function void queue_noise();
      logic [31:0] first;
      first = $urandom();
      if ($urandom_range(0, 1) == 1) first[31:16] = $urandom_range(0, 1) ? KindPixel : KindVertex;
      push_token(first, 1'($urandom_range(0, 3) == 0));
      repeat ($urandom_range(0, 11)) begin
         if ($urandom_range(0, 99) < 5) push_empty();
         else push_token($urandom(), 1'($urandom_range(0, 3) == 0));
      end
   endfunction

   task automatic send_request(input item_type it);
      while ($urandom_range(0, 99) < send_idle) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid         <= 1'b1;
      req_if.token         <= it.token;
      req_if.last          <= it.last;
      req_if.empty_program <= it.empty_program;
      do @(posedge clock); while (!req_if.ready);
      tracker.note_token(it);
   endtask

   task automatic drain_stream();
      while (stream_q.size() != 0) send_request(stream_q.pop_front());
   endtask

   task automatic run_phase(input int idle, input int stall);
      int count;
      count      = 0;
      send_idle  = idle;
      recv_stall = stall;
      while (count < PhaseItems) begin
         if ($urandom_range(0, 99) < 85) queue_program();
         else queue_noise();
         count += stream_q.size();
         drain_stream();
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.token         = '0;
      req_if.last          = 1'b0;
      req_if.empty_program = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      queue_directed();
      drain_stream();
      run_phase(0, 0);
      run_phase(45, 0);
      run_phase(0, 45);
      run_phase(17, 17);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (tracker.pending_masks.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("shader_sampler_mask_scan: match");
      end else begin
         $display("shader_sampler_mask_scan: mismatch");
      end
      $finish;
   end

endmodule
